// File: hdl/am_fm_resynthesis_oscillator_macros.svh
// Assertion macros shared by the checker.
`ifndef AM_FM_RESYNTHESIS_OSCILLATOR_MACROS_SVH
`define AM_FM_RESYNTHESIS_OSCILLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AFO_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define AFO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/amfm_osc_pkg.sv
package amfm_osc_pkg;

    // phase accumulator and cosine table sizes
    localparam int PHASE_BITS     = 32;
    localparam int COS_TABLE_BITS = 10;
    localparam int TAB_N          = 1 << COS_TABLE_BITS;
    localparam int TAB_AW         = COS_TABLE_BITS + 1;

    // field widths
    localparam int FREQ_W  = 24;
    localparam int AMP_W   = 16;
    localparam int PITCH_W = 16;
    localparam int RATIO_W = 18;
    localparam int SPH_W   = 40;
    localparam int OUT_W   = 16;
    localparam int COS_W   = 17;

    // serial multiplier sizes
    localparam int MC_W   = FREQ_W + RATIO_W;
    localparam int ACC_W  = MC_W + 1;
    localparam int MP_W   = SPH_W;
    localparam int PROD_W = MC_W + MP_W;
    localparam int CNT_W  = $clog2(MP_W);

    // step = floor(freq * ratio * step_per_hz / 2^33)
    localparam int STEP_LSB = 33;
    localparam int AMP_PROD_W = COS_W + AMP_W;
    localparam int OUT_SHIFT  = 15;

    // configuration
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KNOB  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PER_HZ = 8'd1;
    localparam logic [SPH_W-1:0]     SPH_RESET       = 40'd22906492;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FREQ_MUL,
        ST_STEP_LOAD,
        ST_STEP_MUL,
        ST_PHASE,
        ST_COS_READ,
        ST_AMP_LOAD,
        ST_AMP_MUL,
        ST_DELIVER
    } osc_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic neg_step;
    } mul_ctl_t;

    typedef logic [15:0] cos_tab_t [0:TAB_N];

    // quarter-wave cosine, Q30 Taylor series then rounded to Q.15
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t    t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        for (int k = 0; k <= TAB_N; k++) begin
            x    = (64'(k) * HALF_PI_Q30) >> COS_TABLE_BITS;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            t[k] = 16'((64'(sum) + 64'd16384) >> 15);
        end
        return t;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// File: hdl/amfm_osc_serial_mul.sv
// Radix-2 shift-add multiplier: signed multiplicand, one multiplier bit per step.
// Product = {acc, lo} with the low bits entering lo from the top.
module amfm_osc_serial_mul
    import amfm_osc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mul_ctl_t                ctl,
    input  logic signed [MC_W-1:0]  mcand,
    input  logic        [MP_W-1:0]  mplier,
    output logic signed [ACC_W-1:0] acc,
    output logic        [MP_W-1:0]  lo
);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic        [MP_W-1:0]  lo_reg, lo_next;
    logic        [MP_W-1:0]  mpl_reg, mpl_next;
    logic signed [MC_W-1:0]  mc_reg, mc_next;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] sum;

    always_comb
    begin
        addend = mpl_reg[0] ? {mc_reg[MC_W-1], mc_reg} : '0;
        if (ctl.neg_step)
            addend = -addend;
        sum = acc_reg + addend;

        acc_next = acc_reg;
        lo_next  = lo_reg;
        mpl_next = mpl_reg;
        mc_next  = mc_reg;
        if (ctl.load)
        begin
            acc_next = '0;
            lo_next  = '0;
            mpl_next = mplier;
            mc_next  = mcand;
        end
        else if (ctl.step)
        begin
            acc_next = sum >>> 1;
            lo_next  = {sum[0], lo_reg[MP_W-1:1]};
            mpl_next = mpl_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            lo_reg  <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            lo_reg  <= lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mpl_reg <= mpl_next;
        mc_reg  <= mc_next;
    end

    assign acc = acc_reg;
    assign lo  = lo_reg;

endmodule

// File: hdl/am_fm_resynthesis_oscillator.sv
// AM/FM resynthesis oscillator.
// Sample channel: sample_valid / sample_stall with freq_hz (Q16.8, signed) and
// amplitude (Q5.11, signed). A request is taken when valid is high and stall low.
// Result channel: result_valid / result_stall with audio_out (Q5.11, signed),
// one result per sample request, amplitude x cos(phase).
// Config channel: cfg_valid / cfg_ready, cfg_index 0 = pitch_knob, 1 = step_per_hz;
// other indexes are dropped. cfg_ready is always high; write only while idle.
// Sequence: one sample at a time through a shared bit-serial multiplier:
// 18 steps for freq x ratio, 40 steps for x step_per_hz, 16 steps for
// amplitude x cosine, plus phase add, cosine ROM read and loads, 74
// multiplier steps in all. audio_out comes from an output register;
// sample_stall stays high until the block is back in idle, so a new sample
// is taken only after the last one has left the sequencer.
// The result sits in an output register; a stalled receiver keeps it there and
// the block holds a finished sample in its last state until the register frees.
// Reset: phase to zero, pitch_knob to 0, step_per_hz to 2^32/48k in Q32.8, no
// result pending. No clearing pass: the cosine table is a constant ROM.
module am_fm_resynthesis_oscillator
    import amfm_osc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  logic signed [FREQ_W-1:0] freq_hz,
    input  logic signed [AMP_W-1:0] amplitude,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [OUT_W-1:0] audio_out,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [SPH_W-1:0]        cfg_data
);

    osc_state_t state_reg, state_next;

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [PITCH_W-1:0]     pitch_reg;
    logic [SPH_W-1:0]       sph_reg;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic signed [AMP_W-1:0] amp_reg;
    logic [15:0]            cos_mag_reg;
    logic                   cos_neg_reg;
    logic                   out_valid_reg;
    logic signed [OUT_W-1:0] audio_reg;

    // shared multiplier
    mul_ctl_t               mul_ctl;
    logic signed [MC_W-1:0] mul_mcand;
    logic [MP_W-1:0]        mul_mplier;
    logic signed [ACC_W-1:0] mul_acc;
    logic [MP_W-1:0]        mul_lo;

    logic                   sample_take;
    logic                   cfg_take;
    logic                   out_free;
    logic [RATIO_W-1:0]     ratio;
    logic signed [MC_W-1:0] fr;
    logic [PROD_W-1:0]      prod_full;
    logic [PHASE_BITS-1:0]  step;
    logic [1:0]             quad;
    logic [COS_TABLE_BITS-1:0] tab_idx;
    logic [TAB_AW-1:0]      tab_addr;
    logic signed [COS_W-1:0] cos_s;
    logic signed [AMP_PROD_W-1:0] amp_prod;
    logic signed [AMP_PROD_W:0]   amp_rnd;
    logic signed [AMP_PROD_W-OUT_SHIFT:0] amp_res;
    logic signed [OUT_W-1:0] audio_sat;

    assign sample_stall = (state_reg != ST_IDLE);
    assign sample_take  = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;
    assign cfg_take     = cfg_valid && cfg_ready;
    assign out_free     = !out_valid_reg || !result_stall;

    // ratio = 0.5 + 1.5 * pitch, Q.17
    assign ratio = RATIO_W'(1 << PITCH_W) + {1'b0, pitch_reg, 1'b0}
                   + {2'b00, pitch_reg};

    // freq x ratio after its steps: sign part in acc, low bits at top of lo
    assign fr = {mul_acc[MC_W-RATIO_W-1:0], mul_lo[MP_W-1 -: RATIO_W]};

    // full 82-bit product after the step_per_hz pass
    assign prod_full = {mul_acc[MC_W-1:0], mul_lo};
    assign step      = prod_full[STEP_LSB +: PHASE_BITS];

    // quarter-wave lookup: odd quadrants mirror the index, middle two negate
    assign quad     = phase_reg[PHASE_BITS-1 -: 2];
    assign tab_idx  = phase_reg[PHASE_BITS-3 -: COS_TABLE_BITS];
    assign tab_addr = quad[0] ? TAB_AW'(TAB_N) - {1'b0, tab_idx} : {1'b0, tab_idx};

    assign cos_s = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});

    // amplitude x cosine, Q.26, round half up to Q.11 (floor of (v + 2^14) / 2^15)
    assign amp_prod = {mul_acc[COS_W-1:0], mul_lo[MP_W-1 -: AMP_W]};
    assign amp_rnd  = {amp_prod[AMP_PROD_W-1], amp_prod} + (AMP_PROD_W+1)'(1 << (OUT_SHIFT - 1));
    assign amp_res  = amp_rnd[AMP_PROD_W:OUT_SHIFT];

    always_comb
    begin
        // full-scale negative amplitude times cos = -1 lands one above the top
        if (amp_res > $signed((AMP_PROD_W-OUT_SHIFT+1)'((1 << (OUT_W - 1)) - 1)))
            audio_sat = {1'b0, {(OUT_W-1){1'b1}}};
        else if (amp_res < -$signed((AMP_PROD_W-OUT_SHIFT+1)'(1 << (OUT_W - 1))))
            audio_sat = {1'b1, {(OUT_W-1){1'b0}}};
        else
            audio_sat = amp_res[OUT_W-1:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mul_ctl    = '0;
        mul_mcand  = {{(MC_W-FREQ_W){freq_hz[FREQ_W-1]}}, freq_hz};
        mul_mplier = {{(MP_W-RATIO_W){1'b0}}, ratio};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_take)
                begin
                    mul_ctl.load = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_FREQ_MUL;
                end
            end
            ST_FREQ_MUL:
            begin
                mul_ctl.step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RATIO_W - 1))
                    state_next = ST_STEP_LOAD;
            end
            ST_STEP_LOAD:
            begin
                mul_ctl.load = 1'b1;
                mul_mcand    = fr;
                mul_mplier   = sph_reg;
                cnt_next     = '0;
                state_next   = ST_STEP_MUL;
            end
            ST_STEP_MUL:
            begin
                mul_ctl.step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SPH_W - 1))
                    state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                state_next = ST_COS_READ;
            end
            ST_COS_READ:
            begin
                state_next = ST_AMP_LOAD;
            end
            ST_AMP_LOAD:
            begin
                mul_ctl.load = 1'b1;
                mul_mcand    = {{(MC_W-COS_W){cos_s[COS_W-1]}}, cos_s};
                mul_mplier   = {{(MP_W-AMP_W){1'b0}}, amp_reg};
                cnt_next     = '0;
                state_next   = ST_AMP_MUL;
            end
            ST_AMP_MUL:
            begin
                // sign bit of amplitude carries negative weight
                mul_ctl.step     = 1'b1;
                mul_ctl.neg_step = (cnt_reg == CNT_W'(AMP_W - 1));
                cnt_next         = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(AMP_W - 1))
                    state_next = ST_DELIVER;
            end
            ST_DELIVER:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    amfm_osc_serial_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .mcand  (mul_mcand),
        .mplier (mul_mplier),
        .acc    (mul_acc),
        .lo     (mul_lo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pitch_reg     <= '0;
            sph_reg       <= SPH_RESET;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (cfg_take)
            begin
                unique case (cfg_index)
                    CFG_PITCH_KNOB:  pitch_reg <= cfg_data[PITCH_W-1:0];
                    CFG_STEP_PER_HZ: sph_reg   <= cfg_data;
                    default:         ;
                endcase
            end

            if (state_reg == ST_PHASE)
                phase_reg <= phase_reg + step;

            if (state_reg == ST_DELIVER && out_free)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers and cosine ROM with registered read
    always_ff @(posedge clk)
    begin
        if (sample_take)
            amp_reg <= amplitude;
        if (state_reg == ST_COS_READ)
        begin
            cos_mag_reg <= COS_TAB[tab_addr];
            cos_neg_reg <= quad[1] ^ quad[0];
        end
        if (state_reg == ST_DELIVER && out_free)
            audio_reg <= audio_sat;
    end

    assign result_valid = out_valid_reg;
    assign audio_out    = audio_reg;

endmodule

// File: hdl/amfm_osc_checker.sv
`include "am_fm_resynthesis_oscillator_macros.svh"

module amfm_osc_checker
    import amfm_osc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     sample_valid,
    input logic                     sample_stall,
    input logic                     result_valid,
    input logic                     result_stall,
    input logic signed [OUT_W-1:0]  audio_out
);

    // a pending result holds until taken
    `AFO_ASSERT_NEXT(a_result_hold,
        result_valid && result_stall,
        result_valid && $stable(audio_out),
        "result dropped or changed under stall")

    // one sample in flight: a taken request makes the block busy
    `AFO_ASSERT_NEXT(a_busy_after_take,
        sample_valid && !sample_stall,
        sample_stall,
        "request taken while a sample is in flight")

    // a new result only ever closes out a busy period
    `AFO_ASSERT_NOW(a_result_from_busy,
        $rose(result_valid),
        $past(sample_stall),
        "result appeared without a sample in flight")

    // no result the cycle after a request is taken
    `AFO_ASSERT_NEXT(a_no_instant_result,
        sample_valid && !sample_stall,
        !$rose(result_valid),
        "result too early after request")

endmodule

bind am_fm_resynthesis_oscillator amfm_osc_checker u_checker (.*);

// File: tb/tb_am_fm_resynthesis_oscillator.sv
module tb_am_fm_resynthesis_oscillator;
    import amfm_osc_pkg::*;

    // watchdog: cycles with no request on any channel
    localparam int STALL_LIMIT  = 5000;
    // receiver hold-off that backs the block up
    localparam int HOLD_CYCLES  = 600;
    // tail after the last result, about one sample's latency
    localparam int TAIL_CYCLES  = 100;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int MAX_REPORTS  = 200;

    // register indexes that the block must drop
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

    localparam logic [SPH_W-1:0] SPH_MAX     = 40'hFF_FFFF_FFFF;
    // 2^38 with pitch 0 gives a step of freq * 2^21: 512 is a quarter turn
    localparam logic [SPH_W-1:0] SPH_QUARTER = 40'h40_0000_0000;

    // Scoreboard: own copy of pitch, step_per_hz and the phase accumulator,
    // plus the queue of audio samples still owed by the block.
    class audio_scoreboard;
        logic [PITCH_W-1:0]      pitch;
        logic [SPH_W-1:0]        step_hz;
        logic [PHASE_BITS-1:0]   phase;
        int                      cos_q15 [0:TAB_N];
        logic signed [OUT_W-1:0] pending_audio [$];
        int                      errors;
        int                      checked;

        function new();
            logic [63:0] ang;
            logic [63:0] ang_sq;
            logic [63:0] term;
            longint      acc;
            pitch   = '0;
            step_hz = SPH_RESET;
            phase   = '0;
            errors  = 0;
            checked = 0;
            // quarter-wave cosine: Q30 Taylor sum, clamped at 0, rounded to Q.15
            for (int k = 0; k <= TAB_N; k++) begin
                ang    = (64'(k) * 64'd1686629713) >> COS_TABLE_BITS;
                ang_sq = (ang * ang) >> 30;
                term   = 64'd1 << 30;
                acc    = 64'sd1 << 30;
                for (int n = 1; n <= 12; n++) begin
                    term = ((term * ang_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
                    if (n % 2 == 1)
                        acc -= longint'(term);
                    else
                        acc += longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                cos_q15[k] = int'((acc + 16384) >>> 15);
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SPH_W-1:0] data);
            if (idx == CFG_PITCH_KNOB)
                pitch = data[PITCH_W-1:0];
            else if (idx == CFG_STEP_PER_HZ)
                step_hz = data;
        endfunction

        // advance the phase by one accepted sample and queue the audio it owes
        function void predict_audio(logic signed [FREQ_W-1:0] f,
                                    logic signed [AMP_W-1:0] a);
            longint                  ratio;
            logic signed [95:0]      fr_w;
            logic signed [95:0]      sph_w;
            logic signed [95:0]      prod;
            logic [1:0]              quad;
            logic [COS_TABLE_BITS-1:0] idx;
            longint                  c;
            longint                  v;
            ratio = 65536 + 3 * longint'(pitch);
            fr_w  = longint'(f) * ratio;
            sph_w = {56'd0, step_hz};
            prod  = fr_w * sph_w;
            // bits above the shift give floor() mod 2^PHASE_BITS
            phase = phase + prod[STEP_LSB +: PHASE_BITS];
            quad  = phase[PHASE_BITS-1 -: 2];
            idx   = phase[PHASE_BITS-3 -: COS_TABLE_BITS];
            case (quad)
                2'd0:    c =  cos_q15[idx];
                2'd1:    c = -cos_q15[TAB_N - idx];
                2'd2:    c = -cos_q15[idx];
                default: c =  cos_q15[TAB_N - idx];
            endcase
            v = (longint'(a) * c + 16384) >>> OUT_SHIFT;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            pending_audio.push_back(OUT_W'(v));
        endfunction

        function void check_audio(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            checked++;
            if (pending_audio.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: audio_out %0d with no sample outstanding", $time, got);
                return;
            end
            want = pending_audio.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: audio_out mismatch: expected %0d, actual %0d",
                             $time, want, got);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     sample_valid;
    logic                     sample_stall;
    logic signed [FREQ_W-1:0] freq_hz;
    logic signed [AMP_W-1:0]  amplitude;
    logic                     result_valid;
    logic                     result_stall;
    logic signed [OUT_W-1:0]  audio_out;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [SPH_W-1:0]         cfg_data;

    audio_scoreboard sb;
    bit idle_on;        // random gaps and stalls allowed
    bit long_hold;      // receiver holds off for HOLD_CYCLES
    int n_samples;
    int n_writes;
    int n_settings;
    int idle_cycles;

    am_fm_resynthesis_oscillator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .freq_hz      (freq_hz),
        .amplitude    (amplitude),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .audio_out    (audio_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor and watchdog. Runs right after the rising edge, so it sees the
    // values that were present at the edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (sample_valid && !sample_stall) begin
                sb.predict_audio(freq_hz, amplitude);
                n_samples++;
            end
            if (result_valid && !result_stall)
                sb.check_audio(audio_out);
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                n_writes++;
            end
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("tb_am_fm_resynthesis_oscillator NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, or one long hold-off on request.
    // Each branch leaves result_stall at most once per falling edge.
    always
    begin
        @(negedge clk);
        if (long_hold) begin
            result_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            long_hold = 1'b0;
            result_stall <= 1'b0;
        end
        else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
            result_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clk);
            result_stall <= 1'b0;
        end
        else begin
            result_stall <= 1'b0;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input logic signed [FREQ_W-1:0] f,
                               input logic signed [AMP_W-1:0] a);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        sample_valid <= 1'b1;
        freq_hz      <= f;
        amplitude    <= a;
        do @(posedge clk); while (sample_stall);
        @(negedge clk);
    endtask

    // One register write, valid dropped for a cycle afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SPH_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering samples and wait until every owed result is back.
    task automatic drain;
        sample_valid <= 1'b0;
        while (sb.pending_audio.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        logic [PITCH_W-1:0]      pitch_v;
        logic [SPH_W-1:0]        sph_v;
        logic [PHASE_BITS-1:0]   back_to_zero;
        logic signed [FREQ_W-1:0] f;
        logic signed [AMP_W-1:0]  a;
        int                      kind;

        sb           = new();
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        freq_hz      = '0;
        amplitude    = '0;
        result_stall = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_on      = 1'b1;
        long_hold    = 1'b0;
        n_samples    = 0;
        n_writes     = 0;
        n_settings   = 1;
        idle_cycles  = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // --- directed: reset register values (48 kHz step, pitch 0)
        send_sample(24'sd112640, 16'sd32767);       // 440 Hz
        send_sample(-24'sd112640, 16'sd32767);      // negative frequency
        send_sample(24'sd0, -16'sd32768);
        send_sample(24'sh7FFFFF, 16'sd32767);       // field extremes
        send_sample(24'sh800000, -16'sd32768);
        send_sample(24'sd256000, 16'sd0);
        drain();

        // --- directed: realign phase to zero, then step in exact quarter turns.
        // With pitch 0 and freq 2^17 the step equals step_per_hz mod 2^32.
        back_to_zero = '0 - sb.phase;
        write_reg(CFG_PITCH_KNOB, '0);
        write_reg(CFG_STEP_PER_HZ, {8'd0, back_to_zero});
        write_reg(CFG_UNUSED_LO, '0);               // dropped indexes
        write_reg(CFG_UNUSED_HI, SPH_MAX);
        n_settings++;
        send_sample(24'sd131072, 16'sd32767);       // lands on phase 0
        drain();
        write_reg(CFG_STEP_PER_HZ, SPH_QUARTER);
        n_settings++;
        send_sample(24'sd0, -16'sd32768);           // cos = +1
        send_sample(24'sd1024, -16'sd32768);        // half turn: -full x -1 saturates
        send_sample(24'sd1024, 16'sd32767);         // back to zero
        send_sample(24'sd512, 16'sd32767);          // quarter turn
        send_sample(24'sd1024, -16'sd32768);        // three quarters
        send_sample(-24'sd1024, -16'sd32768);       // backwards half turn
        send_sample(24'sd512, -16'sd32768);         // half turn again, saturates
        drain();

        // --- directed: largest ratio and step
        write_reg(CFG_PITCH_KNOB, 16'hFFFF);
        write_reg(CFG_STEP_PER_HZ, SPH_MAX);
        n_settings++;
        send_sample(24'sh7FFFFF, 16'sd32767);
        send_sample(24'sh800000, -16'sd32768);
        send_sample(-24'sd1, 16'sd1);
        send_sample(24'sd1, -16'sd1);
        send_sample(24'sd0, 16'sd32767);
        drain();

        // --- random phases, each with its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       pitch_v = '0;
                1:       pitch_v = 16'hFFFF;
                default: pitch_v = PITCH_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       sph_v = '0;
                1:       sph_v = SPH_MAX;
                2:       sph_v = SPH_RESET;
                3:       sph_v = SPH_QUARTER;
                4:       sph_v = {8'($urandom_range(0, 255)), 32'($urandom)};
                default: sph_v = SPH_W'($urandom_range(1, 1 << 26));
            endcase
            write_reg(CFG_PITCH_KNOB, pitch_v);
            write_reg(CFG_STEP_PER_HZ, sph_v);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 255)),
                          {8'($urandom), 32'($urandom)});
            n_settings++;

            // last phase runs flat out; one phase backs the block up
            idle_on = (ph != RAND_PHASES - 1);
            if (ph == 2)
                long_hold = 1'b1;

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                kind = $urandom_range(0, 9);
                if (kind <= 3)
                    f = FREQ_W'($urandom);
                else if (kind <= 6) begin
                    f = FREQ_W'($urandom_range(0, 20000 * 256));
                    if ($urandom_range(0, 1))
                        f = -f;
                end
                else if (kind <= 8)
                    f = FREQ_W'((int'($urandom_range(0, 64)) - 32) * 512);
                else
                    f = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                case ($urandom_range(0, 9))
                    6:       a = 16'sd32767;
                    7:       a = -16'sd32768;
                    8:       a = 16'sd0;
                    9:       a = AMP_W'(int'($urandom_range(0, 255)) - 128);
                    default: a = AMP_W'($urandom);
                endcase
                send_sample(f, a);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d samples and %0d results checked over %0d register settings",
                 n_samples, sb.checked, n_settings);
        $display("%0d register writes, including dropped indexes", n_writes);
        if (sb.pending_audio.size() != 0)
            $display("%0t: %0d expected audio samples never arrived",
                     $time, sb.pending_audio.size());
        if (sb.errors == 0 && sb.pending_audio.size() == 0)
            $display("tb_am_fm_resynthesis_oscillator OK");
        else
            $display("tb_am_fm_resynthesis_oscillator NOT OK");
        $finish;
    end

endmodule
